// ===== rtl/lmrx_pkg.sv =====
// shared types and constants for the line mode receive fifo
`timescale 1ns / 1ps
`default_nettype none
package lmrx_pkg;

  // request codes on req_type
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_MARK = 2'd2;

  // control characters
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;

  // upper bound on results per read
  localparam int MAX_RESULTS = 64;

  // register byte offsets
  localparam logic [2:0] ADDR_RAW_MODE = 3'd0;

  typedef enum logic [1:0] {
    K_BYTE = 2'd0,
    K_READ = 2'd1,
    K_MARK = 2'd2,
    K_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [6:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        last;
    logic        dropped;
    logic [6:0]  queued;
    logic        line_ready;
    logic        overflowed;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_EMIT  = 3'b100
  } bstate_t;

endpackage
`default_nettype wire

// ===== rtl/line_mode_rx_fifo_top.sv =====
// top level of the line mode receive fifo
//
// input channel: push/full with req_type, rx_byte, read_len; a transfer happens
// on a rising edge with push high and full low. the front queue holds two
// requests, so full only rises when the back end falls behind.
// result channel: empty/pop; the oldest result sits on the result ports while
// empty is low and leaves on a rising edge with pop high.
// a received byte, a command mark or an unused code gives one result, moved from
// the front queue into the result register once the result register is free.
// a read request gives one result per popped byte (at least one result);
// each popped byte goes through S_ISSUE, which addresses the fifo ram, and S_EMIT,
// which loads its registered read data into the result register when that is free.
// when the receiver stalls, the result register holds and the back end waits;
// the front queue keeps taking requests until both slots are filled.
// reset (rst, synchronous) empties the fifo, clears the line, command and
// overflow flags, sets raw_mode to 0 and drops any queued request or result.
// apb register at byte 0: bit 0 raw_mode; pready is always high.
`timescale 1ns / 1ps
`default_nettype none
module line_mode_rx_fifo_top
  import lmrx_pkg::*;
#(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [6:0]  read_len,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       read_data,
  output logic             data_valid,
  output logic             last,
  output logic             byte_dropped,
  output logic [6:0]       bytes_queued,
  output logic             line_ready,
  output logic             overflowed,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic raw_mode;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic out_valid;
  res_t res;

  // register file: raw_mode reads back at byte 0 only; writes to bytes 0 to 3 set it
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RAW_MODE) ? {31'd0, raw_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_RAW_MODE[2])) begin
      raw_mode <= pwdata[0];
    end
  end

  // request classification and queueing
  lmrx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .read_len  (read_len),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // line discipline and fifo
  lmrx_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .raw_mode  (raw_mode),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .res       (res),
    .pop       (pop)
  );

  // result register fields out to the ports
  assign empty        = !out_valid;
  assign read_data    = res.data;
  assign data_valid   = res.valid;
  assign last         = res.last;
  assign byte_dropped = res.dropped;
  assign bytes_queued = res.queued;
  assign line_ready   = res.line_ready;
  assign overflowed   = res.overflowed;

endmodule
`default_nettype wire

// ===== rtl/lmrx_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lmrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lmrx_front.sv =====
// front end: accepts requests, classifies them and queues two deep
`timescale 1ns / 1ps
`default_nettype none
module lmrx_front
  import lmrx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] rx_byte,
  input  wire logic [6:0] read_len,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_take
);

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_take;
  cmd_t       incoming;

  always_comb begin
    incoming.data = rx_byte;
    incoming.len  = read_len;
    unique case (req_type)
      REQ_BYTE: incoming.kind = K_BYTE;
      REQ_READ: incoming.kind = K_READ;
      REQ_MARK: incoming.kind = K_MARK;
      default:  incoming.kind = K_NONE;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_take   = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_take};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lmrx_back.sv =====
// back end: line discipline, fifo bookkeeping and result register
`timescale 1ns / 1ps
`default_nettype none
module lmrx_back
  import lmrx_pkg::*;
#(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic raw_mode,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      out_valid,
  output res_t      res,
  input  wire logic pop
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CAP   = (FIFO_DEPTH < MAX_RESULTS) ? FIFO_DEPTH : MAX_RESULTS;

  bstate_t            state, state_next;
  logic [PTR_W-1:0]   head, head_next;
  logic [PTR_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]   fill, fill_next;
  logic [CNT_W-1:0]   rem, rem_next;
  logic               nl, nl_next;
  logic               cd, cd_next;
  logic               ov, ov_next;
  logic               out_valid_next;
  res_t               res_next;
  logic               load;
  logic               out_free;

  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [7:0]         wr_byte;
  logic               rd_en;
  logic [7:0]         rd_data;

  logic               keep;
  logic [7:0]         b_cur;
  logic [6:0]         want;
  logic [CNT_W-1:0]   n_cnt;

  function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  lmrx_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_byte),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid || pop;

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    fill_next  = fill;
    rem_next   = rem;
    nl_next    = nl;
    cd_next    = cd;
    ov_next    = ov;
    cmd_take   = 1'b0;
    load       = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = tail;
    rd_en      = 1'b0;
    keep       = 1'b1;
    b_cur      = cmd.data;
    want       = (cmd.len > 7'(CAP)) ? 7'(CAP) : cmd.len;
    n_cnt      = (want < 7'(fill)) ? CNT_W'(want) : fill;
    wr_byte    = b_cur;
    res_next   = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          case (cmd.kind)
            K_BYTE: begin
              if (cd && nl) begin
                head_next = '0;
                tail_next = '0;
                fill_next = '0;
                nl_next   = 1'b0;
                cd_next   = 1'b0;
              end
              if (!raw_mode) begin
                if (b_cur == CH_CR) begin
                  b_cur = CH_LF;
                end
                if (nl_next) begin
                  keep = 1'b0;
                end else if (b_cur == CH_LF) begin
                  nl_next = 1'b1;
                end else if (b_cur == CH_BS || b_cur == CH_DEL) begin
                  keep = 1'b0;
                end
              end
              wr_byte = b_cur;
              if (keep) begin
                if (fill_next == CNT_W'(FIFO_DEPTH)) begin
                  ov_next = 1'b1;
                end else begin
                  // write slot is the tail after any command clear
                  wr_en     = 1'b1;
                  wr_addr   = tail_next;
                  tail_next = nxt(tail_next);
                  fill_next = fill_next + 1'b1;
                end
              end
              load             = 1'b1;
              res_next.last    = 1'b1;
              res_next.dropped = !keep;
            end
            K_READ: begin
              if (n_cnt == '0) begin
                load          = 1'b1;
                res_next.last = 1'b1;
              end else begin
                rem_next   = n_cnt;
                state_next = S_ISSUE;
              end
            end
            K_MARK: begin
              cd_next       = 1'b1;
              load          = 1'b1;
              res_next.last = 1'b1;
            end
            default: begin
              load          = 1'b1;
              res_next.last = 1'b1;
            end
          endcase
        end
      end
      S_ISSUE: begin
        rd_en      = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load           = 1'b1;
          res_next.data  = rd_data;
          res_next.valid = 1'b1;
          res_next.last  = (rem == CNT_W'(1));
          head_next      = nxt(head);
          fill_next      = fill - 1'b1;
          rem_next       = rem - 1'b1;
          state_next     = (rem == CNT_W'(1)) ? S_IDLE : S_ISSUE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.queued     = 7'(fill_next);
    res_next.line_ready = nl_next;
    res_next.overflowed = ov_next;
    out_valid_next      = load ? 1'b1 : (pop ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      rem       <= '0;
      nl        <= 1'b0;
      cd        <= 1'b0;
      ov        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      fill      <= fill_next;
      rem       <= rem_next;
      nl        <= nl_next;
      cd        <= cd_next;
      ov        <= ov_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(FIFO_DEPTH))
    else $error("fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (head == tail))
    else $error("empty fifo with unequal pointers");

  a_read_rem: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (rem != '0 && rem <= fill))
    else $error("read count out of range");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> $stable(res))
    else $error("waiting result changed");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// self-checking testbench for the line mode receive fifo top level
`timescale 1ns / 1ps
module tb;
  import lmrx_pkg::*;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEG_ITEMS   = 84;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  req_type;
  logic [7:0]  rx_byte;
  logic [6:0]  read_len;
  logic        empty;
  logic        pop;
  logic [7:0]  read_data;
  logic        data_valid;
  logic        last;
  logic        byte_dropped;
  logic [6:0]  bytes_queued;
  logic        line_ready;
  logic        overflowed;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  line_mode_rx_fifo_top #(.FIFO_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .req_type(req_type), .rx_byte(rx_byte), .read_len(read_len),
    .empty(empty), .pop(pop),
    .read_data(read_data), .data_valid(data_valid), .last(last),
    .byte_dropped(byte_dropped), .bytes_queued(bytes_queued),
    .line_ready(line_ready), .overflowed(overflowed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // one row of the directed table; typed rows carry their single expected result
  typedef struct {
    cmd_t req;
    bit   typed;
    res_t want;
  } row_t;

  // shadow of the line discipline state
  logic [7:0]  shadow_mem [DEPTH];
  logic [5:0]  rd_ptr;
  logic [5:0]  wr_ptr;
  int          occupancy;
  bit          line_flag;
  bit          cmd_flag;
  bit          ovf_flag;
  bit          raw_flag;

  res_t        pending_results[$];
  row_t        directed_rows[$];
  res_t        head_result;
  int          mismatch_count;
  int          items_sent;
  int          cycle_count;
  int          send_gap_pct;
  int          pop_stall_pct;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // every mismatch goes through here: one line each
  task automatic report_if_diff(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      mismatch_count++;
      $display("[%0t] ERROR %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  // status result of a byte, mark or unused code, or of a read that pops nothing
  function automatic res_t status_result(bit dropped, logic [6:0] queued, bit ln, bit ovf);
    res_t r;
    r            = '0;
    r.last       = 1'b1;
    r.dropped    = dropped;
    r.queued     = queued;
    r.line_ready = ln;
    r.overflowed = ovf;
    return r;
  endfunction

  // advance the shadow state by one accepted request, queueing what it yields
  function automatic void apply_request(cmd_t c);
    logic [7:0] b;
    bit         keep;
    int         want_n;
    int         n;
    res_t       r;
    case (c.kind)
      K_BYTE: begin
        b    = c.data;
        keep = 1'b1;
        // a finished command empties the fifo before the byte is looked at
        if (cmd_flag && line_flag) begin
          rd_ptr    = '0;
          wr_ptr    = '0;
          occupancy = 0;
          line_flag = 1'b0;
          cmd_flag  = 1'b0;
        end
        if (!raw_flag) begin
          if (b == CH_CR) b = CH_LF;
          if (line_flag) keep = 1'b0;
          else if (b == CH_LF) line_flag = 1'b1;
          else if (b == CH_BS || b == CH_DEL) keep = 1'b0;
        end
        if (keep) begin
          if (occupancy >= DEPTH) begin
            ovf_flag = 1'b1;
          end else begin
            shadow_mem[wr_ptr] = b;
            wr_ptr++;
            occupancy++;
          end
        end
        pending_results.push_back(status_result(!keep, occupancy[6:0], line_flag, ovf_flag));
      end
      K_READ: begin
        want_n = int'(c.len);
        if (want_n > DEPTH) want_n = DEPTH;
        if (want_n > MAX_RESULTS) want_n = MAX_RESULTS;
        n = (want_n < occupancy) ? want_n : occupancy;
        if (n == 0)
          pending_results.push_back(status_result(1'b0, occupancy[6:0], line_flag, ovf_flag));
        for (int i = 0; i < n; i++) begin
          r            = '0;
          r.data       = shadow_mem[rd_ptr];
          r.valid      = 1'b1;
          rd_ptr++;
          occupancy--;
          r.last       = (i == n - 1);
          r.queued     = occupancy[6:0];
          r.line_ready = line_flag;
          r.overflowed = ovf_flag;
          pending_results.push_back(r);
        end
      end
      default: begin
        if (c.kind == K_MARK) cmd_flag = 1'b1;
        pending_results.push_back(status_result(1'b0, occupancy[6:0], line_flag, ovf_flag));
      end
    endcase
  endfunction

  // one request transfer, preceded by a random gap on the sender side;
  // always entered and left right after a rising edge
  task automatic send_item(cmd_t c);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_gap_pct) @(posedge clk);
    end
    push     <= 1'b1;
    req_type <= c.kind;
    rx_byte  <= c.data;
    read_len <= c.len;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_request(c);
    if (c.kind != K_NONE) items_sent++;
  endtask

  task automatic send_fields(kind_t k, logic [7:0] d, logic [6:0] n);
    cmd_t c;
    c.kind = k;
    c.data = d;
    c.len  = n;
    send_item(c);
  endtask

  task automatic add_row(kind_t k, logic [7:0] d, logic [6:0] n, bit typed, res_t want);
    row_t row;
    row.req.kind = k;
    row.req.data = d;
    row.req.len  = n;
    row.typed    = typed;
    row.want     = want;
    directed_rows.push_back(row);
  endtask

  // stop sending and let every expected result drain before touching the register
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_transfer(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_RAW_MODE;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write raw_mode with junk in the upper bits, then read it back
  task automatic set_raw_mode(bit v);
    logic [31:0] w;
    logic [31:0] rd;
    w    = $urandom;
    w[0] = v;
    apb_transfer(1'b1, w, rd);
    raw_flag = v;
    apb_transfer(1'b0, 32'h0, rd);
    report_if_diff("raw_mode readback", 16'(rd[0]), 16'(v));
  endtask

  // random traffic: whole command lines as the most frequent pick, plus fill bursts, reads and noise
  task automatic drive_traffic(int quota);
    int          stop_at;
    int          n;
    int          sel;
    logic [7:0]  b;
    logic [6:0]  len;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // a command line: text, terminator, maybe a read, then the host mark
          n = $urandom_range(0, 12);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
            else b = 8'($urandom_range(32, 126));
            send_fields(K_BYTE, b, 7'($urandom));
          end
          send_fields(K_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF, 7'($urandom));
          if ($urandom_range(0, 1))
            send_fields(K_READ, 8'($urandom), 7'($urandom_range(1, 20)));
          send_fields(K_MARK, 8'($urandom), 7'($urandom));
        end
        4: begin
          // long burst of up to 70 bytes, which can fill the fifo and run it over
          n = $urandom_range(30, 70);
          for (int i = 0; i < n; i++) send_fields(K_BYTE, 8'($urandom), 7'($urandom));
        end
        5, 6: begin
          sel = $urandom_range(0, 9);
          if (sel == 0) len = 7'd0;
          else if (sel == 1) len = 7'($urandom_range(65, 127));
          else if (sel == 2) len = 7'd64;
          else len = 7'($urandom_range(1, 63));
          send_fields(K_READ, 8'($urandom), len);
        end
        7: send_fields(K_MARK, 8'($urandom), 7'($urandom));
        default: send_fields(kind_t'($urandom_range(0, 3)), 8'($urandom), 7'($urandom));
      endcase
    end
  endtask

  // result side: random stalls on pop, every result transfer checked in order
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_if_diff("result with nothing expected", 16'd1, 16'd0);
        end else begin
          head_result = pending_results.pop_front();
          report_if_diff("read_data", 16'(read_data), 16'(head_result.data));
          report_if_diff("data_valid", 16'(data_valid), 16'(head_result.valid));
          report_if_diff("last", 16'(last), 16'(head_result.last));
          report_if_diff("byte_dropped", 16'(byte_dropped), 16'(head_result.dropped));
          report_if_diff("bytes_queued", 16'(bytes_queued), 16'(head_result.queued));
          report_if_diff("line_ready", 16'(line_ready), 16'(head_result.line_ready));
          report_if_diff("overflowed", 16'(overflowed), 16'(head_result.overflowed));
        end
      end
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_mode_rx_fifo_top: mismatch");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    push           = 1'b0;
    req_type       = REQ_BYTE;
    rx_byte        = 8'h00;
    read_len       = 7'd0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = ADDR_RAW_MODE;
    pwdata         = 32'h0;
    rd_ptr         = '0;
    wr_ptr         = '0;
    occupancy      = 0;
    line_flag      = 1'b0;
    cmd_flag       = 1'b0;
    ovf_flag       = 1'b0;
    raw_flag       = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    cycle_count    = 0;
    send_gap_pct   = 6;
    pop_stall_pct  = 75;

    // directed table, text mode straight out of reset
    // read of an empty fifo, with a nonzero and a zero length
    add_row(K_READ, 8'hA5, 7'd1, 1, status_result(0, 0, 0, 0));
    add_row(K_READ, 8'h5A, 7'd0, 1, status_result(0, 0, 0, 0));
    add_row(K_BYTE, 8'h41, 7'd0, 1, status_result(0, 1, 0, 0));
    // backspace and delete are filtered out
    add_row(K_BYTE, CH_BS, 7'd0, 1, status_result(1, 1, 0, 0));
    add_row(K_BYTE, CH_DEL, 7'd0, 1, status_result(1, 1, 0, 0));
    add_row(K_BYTE, 8'h00, 7'h7F, 1, status_result(0, 2, 0, 0));
    add_row(K_BYTE, 8'hFF, 7'd0, 1, status_result(0, 3, 0, 0));
    // unused request code leaves the state alone
    add_row(K_NONE, 8'hFF, 7'h7F, 1, status_result(0, 3, 0, 0));
    // cr is stored as lf and raises the line flag
    add_row(K_BYTE, CH_CR, 7'd0, 1, status_result(0, 4, 1, 0));
    // anything after a pending newline is dropped, another newline too
    add_row(K_BYTE, 8'h42, 7'd0, 1, status_result(1, 4, 1, 0));
    add_row(K_BYTE, CH_LF, 7'd0, 1, status_result(1, 4, 1, 0));
    add_row(K_READ, 8'h00, 7'd2, 0, '0);
    add_row(K_MARK, 8'h00, 7'd0, 1, status_result(0, 2, 1, 0));
    // pending line plus command mark: the next byte starts on a clean fifo
    add_row(K_BYTE, 8'h43, 7'd0, 1, status_result(0, 1, 0, 0));
    // oversized read length saturates; here it takes the one held byte, then a 64-byte read finds none
    add_row(K_READ, 8'h00, 7'h7F, 0, '0);
    add_row(K_READ, 8'h00, 7'd64, 1, status_result(0, 0, 0, 0));
    add_row(K_BYTE, CH_LF, 7'd0, 1, status_result(0, 1, 1, 0));
    add_row(K_MARK, 8'h00, 7'd0, 1, status_result(0, 1, 1, 0));
    add_row(K_MARK, 8'h00, 7'd0, 1, status_result(0, 1, 1, 0));
    add_row(K_READ, 8'h00, 7'd1, 0, '0);
    // clear happens even when the byte itself is then filtered
    add_row(K_BYTE, CH_DEL, 7'd0, 1, status_result(1, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].req);
      // typed rows yield one result: it replaces the predicted one
      if (directed_rows[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(directed_rows[i].want);
      end
    end

    // three idle profiles, each run in raw and in text mode
    for (int seg = 0; seg < 6; seg++) begin
      wait_idle();
      case (seg / 2)
        0: begin
          send_gap_pct  = 6;
          pop_stall_pct = 75;
        end
        1: begin
          send_gap_pct  = 75;
          pop_stall_pct = 6;
        end
        default: begin
          send_gap_pct  = 0;
          pop_stall_pct = 0;
        end
      endcase
      set_raw_mode(seg % 2 == 0);
      drive_traffic(SEG_ITEMS);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("line_mode_rx_fifo_top: match");
    end else begin
      $display("line_mode_rx_fifo_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lmrx_pkg.sv
rtl/lmrx_ram.sv
rtl/lmrx_front.sv
rtl/lmrx_back.sv
rtl/line_mode_rx_fifo_top.sv
bench/tb.sv
